// ----- hw/rtl/gtbds_pkg.sv -----
`default_nettype none
package gtbds_pkg;
    localparam int WEIGHT_BITS = 24;
    localparam int SUM_W = WEIGHT_BITS + 2;
    localparam int ACC_W = WEIGHT_BITS + 10;
    localparam int DIV_STAGES = 8;

    localparam logic [2:0] CFG_FORCE_MASK = 3'd0;
    localparam logic [2:0] CFG_CHECK_MASK = 3'd1;
    localparam logic [2:0] CFG_TEXTURED = 3'd2;
    localparam logic [2:0] CFG_RAW_TEXTURE = 3'd3;
    localparam logic [2:0] CFG_DITHER = 3'd4;
    localparam logic [2:0] CFG_BLEND_MODE = 3'd5;

    localparam logic [2:0] BLEND_AVG = 3'd0;
    localparam logic [2:0] BLEND_ADD = 3'd1;
    localparam logic [2:0] BLEND_SUB = 3'd2;
    localparam logic [2:0] BLEND_QUARTER = 3'd3;
    localparam logic [2:0] BLEND_OPAQUE = 3'd4;

    typedef struct packed {
        logic [24:0] texel;
        logic [24:0] background;
        logic [3:0]  phase;
    } t_side;

    typedef struct packed {
        logic       force_mask;
        logic       check_mask;
        logic       textured;
        logic       raw_texture;
        logic       dither_enable;
        logic [2:0] blend_mode;
    } t_cfg;

    function automatic logic signed [3:0] dither_ofs(input logic [3:0] phase);
        logic signed [3:0] v;
        case (phase)
            4'd0: v = -4'sd4;  4'd1: v = 4'sd0;   4'd2: v = -4'sd3;  4'd3: v = 4'sd1;
            4'd4: v = 4'sd2;   4'd5: v = -4'sd2;  4'd6: v = 4'sd3;   4'd7: v = -4'sd1;
            4'd8: v = -4'sd3;  4'd9: v = 4'sd1;   4'd10: v = -4'sd4; 4'd11: v = 4'sd0;
            4'd12: v = 4'sd3;  4'd13: v = -4'sd1; 4'd14: v = 4'sd2;  default: v = -4'sd2;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/gtbds_interp.sv -----
`default_nettype none
module gtbds_interp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [71:0]                   i_weights,
    input  wire logic [71:0]                   i_colors,
    input  wire gtbds_pkg::t_side              i_side,
    output logic                               o_valid,
    output logic [3*gtbds_pkg::ACC_W-1:0]      o_acc,
    output logic [gtbds_pkg::SUM_W-1:0]        o_sum,
    output gtbds_pkg::t_side                   o_side
);
    import gtbds_pkg::*;
    localparam int PW = WEIGHT_BITS + 8;

    logic            r_v1;
    logic [PW-1:0]   r_prod [9];
    logic [WEIGHT_BITS-1:0] r_w [3];
    t_side           r_side1;
    logic            r_v2;
    logic [ACC_W-1:0] r_acc [3];
    logic [SUM_W-1:0] r_sum;
    t_side           r_side2;

    // stage 1: nine weight x channel products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            for (int v = 0; v < 3; v++) begin
                r_w[v] <= i_weights[24*v +: WEIGHT_BITS];
                for (int k = 0; k < 3; k++) begin
                    r_prod[3*k+v] <= PW'(i_weights[24*v +: WEIGHT_BITS])
                                   * PW'(i_colors[24*v+8*k +: 8]);
                end
            end
            r_side1 <= i_side;
            // stage 2: channel sums and weight sum, zero sum divides by one
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= ACC_W'(r_prod[3*k]) + ACC_W'(r_prod[3*k+1])
                          + ACC_W'(r_prod[3*k+2]);
            end
            if ((r_w[0] | r_w[1] | r_w[2]) == '0) begin
                r_sum <= SUM_W'(1);
            end else begin
                r_sum <= SUM_W'(r_w[0]) + SUM_W'(r_w[1]) + SUM_W'(r_w[2]);
            end
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_acc = {r_acc[2], r_acc[1], r_acc[0]};
    assign o_sum = r_sum;
    assign o_side = r_side2;
endmodule
`default_nettype wire

// ----- hw/rtl/gtbds_divider.sv -----
`default_nettype none
module gtbds_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [3*gtbds_pkg::ACC_W-1:0] i_acc,
    input  wire logic [gtbds_pkg::SUM_W-1:0]   i_sum,
    input  wire gtbds_pkg::t_side              i_side,
    output logic                               o_valid,
    output logic [23:0]                        o_col,
    output gtbds_pkg::t_side                   o_side
);
    import gtbds_pkg::*;

    // one quotient bit per stage; quotient fits 8 bits as a weighted average
    logic             r_v   [DIV_STAGES];
    logic [ACC_W-1:0] r_rem [DIV_STAGES][3];
    logic [7:0]       r_q   [DIV_STAGES][3];
    logic [SUM_W-1:0] r_sum [DIV_STAGES];
    t_side            r_side [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < DIV_STAGES; s++) r_v[s] <= r_v[s-1];
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_step
        logic [ACC_W-1:0] n_rem [3];
        logic [7:0]       n_q   [3];
        logic [ACC_W-1:0] dvs;
        logic [ACC_W-1:0] rem_in [3];
        logic [7:0]       q_in [3];
        logic [SUM_W-1:0] sum_in;
        always_comb begin
            sum_in = (s == 0) ? i_sum : r_sum[(s == 0) ? 0 : s-1];
            dvs = ACC_W'(sum_in) << (DIV_STAGES - 1 - s);
            for (int k = 0; k < 3; k++) begin
                rem_in[k] = (s == 0) ? i_acc[ACC_W*k +: ACC_W] : r_rem[(s == 0) ? 0 : s-1][k];
                q_in[k] = (s == 0) ? 8'd0 : r_q[(s == 0) ? 0 : s-1][k];
                n_q[k] = q_in[k];
                n_rem[k] = rem_in[k];
                if (rem_in[k] >= dvs) begin
                    n_rem[k] = rem_in[k] - dvs;
                    n_q[k][DIV_STAGES-1-s] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    r_rem[s][k] <= n_rem[k];
                    r_q[s][k] <= n_q[k];
                end
                r_sum[s] <= sum_in;
                r_side[s] <= (s == 0) ? i_side : r_side[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_col = {r_q[DIV_STAGES-1][2], r_q[DIV_STAGES-1][1], r_q[DIV_STAGES-1][0]};
    assign o_side = r_side[DIV_STAGES-1];
endmodule
`default_nettype wire

// ----- hw/rtl/gtbds_shade.sv -----
`default_nettype none
module gtbds_shade (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [23:0]      i_col,
    input  wire gtbds_pkg::t_side i_side,
    input  wire gtbds_pkg::t_cfg  i_cfg,
    output logic                  o_valid,
    output logic [25:0]           o_data
);
    import gtbds_pkg::*;

    logic        r_v1;
    logic [15:0] r_mod [3];
    logic [7:0]  r_col [3];
    t_side       r_side;
    logic        r_v2;
    logic [25:0] r_data;

    logic [25:0]       n_data;
    logic signed [3:0] dofs;
    logic [8:0]        mod9;
    logic [7:0]        f;
    logic [7:0]        b;
    logic signed [10:0] sv;
    logic [7:0]        res [3];
    logic              do_blend;
    logic              tmask;
    logic              discard;

    function automatic logic [7:0] clamp8(input logic signed [10:0] v);
        if (v < 0) return 8'd0;
        if (v > 11'sd255) return 8'd255;
        return v[7:0];
    endfunction

    always_comb begin
        dofs = dither_ofs(r_side.phase);
        tmask = r_side.texel[24];
        do_blend = i_cfg.textured ? tmask : 1'b1;
        discard = (i_cfg.check_mask && r_side.background[24])
               || (i_cfg.textured && r_side.texel[23:0] == 24'd0 && !tmask);
        mod9 = 9'd0;
        f = 8'd0;
        b = 8'd0;
        sv = 11'sd0;
        for (int k = 0; k < 3; k++) begin
            b = r_side.background[8*k +: 8];
            if (i_cfg.textured) begin
                f = r_side.texel[8*k +: 8];
                if (!i_cfg.raw_texture) begin
                    mod9 = r_mod[k][15:7];
                    f = clamp8(11'(signed'({2'b00, mod9})));
                    if (i_cfg.dither_enable) f = clamp8(11'(signed'({3'b000, f})) + 11'(dofs));
                end
            end else begin
                f = r_col[k];
                if (i_cfg.dither_enable) f = clamp8(11'(signed'({3'b000, f})) + 11'(dofs));
            end
            if (do_blend) begin
                case (i_cfg.blend_mode)
                    BLEND_AVG: sv = 11'(({3'b000, b} + {3'b000, f}) >> 1);
                    BLEND_ADD: sv = 11'({3'b000, b}) + 11'({3'b000, f});
                    BLEND_SUB: sv = 11'({3'b000, b}) - 11'({3'b000, f});
                    BLEND_QUARTER: sv = 11'({3'b000, b}) + 11'({5'b00000, f[7:2]});
                    default: sv = 11'({3'b000, f});
                endcase
                res[k] = clamp8(sv);
            end else begin
                res[k] = f;
            end
        end
        if (discard) begin
            n_data = 26'd0;
        end else begin
            n_data = {1'b1, (i_cfg.textured & tmask) | i_cfg.force_mask,
                      res[2], res[1], res[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_mod[k] <= 16'(i_side.texel[8*k +: 8]) * 16'(i_col[8*k +: 8]);
                r_col[k] <= i_col[8*k +: 8];
            end
            r_side <= i_side;
            r_data <= n_data;
        end
    end

    assign o_valid = r_v2;
    assign o_data = r_data;
endmodule
`default_nettype wire

// ----- hw/rtl/gouraud_texel_blend_dither_shader.sv -----
// channel  | dir | handshake                      | payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready  | pixel item, 200-bit tdata
// m_axis   | out | m_axis_tvalid / m_axis_tready  | shaded pixel, 32-bit tdata
// cfg      | in  | i_cfg_valid / o_cfg_ready      | register index and value
//
// One item per cycle while the output is not stalled; the pipe runs through the
// products and sums, the one-bit-per-stage restoring divider, then modulation
// and dither/blend. All stages share one advance enable, so a stalled output
// holds the whole pipe and s_axis_tready follows m_axis_tready.
// Synchronous active-low reset clears valid bits and the config register
// (blend mode resets to opaque). Config is taken every cycle.
`default_nettype none
module gouraud_texel_blend_dither_shader (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // weight_a, weight_b, weight_c, color_a, color_b, color_c, texel,
    // background, pixel_phase from bit 0 up; bits 199:198 zero
    input  wire logic [199:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // out_color 23:0, out_mask 24, write_enable 25, bits 31:26 zero
    output logic [31:0]        m_axis_tdata,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [2:0]    i_cfg_data
);
    import gtbds_pkg::*;

    t_cfg r_cfg;
    logic en;
    t_side side_in;
    logic iv;
    logic [3*ACC_W-1:0] acc;
    logic [SUM_W-1:0] sum;
    t_side side_i;
    logic dv;
    logic [23:0] col;
    t_side side_d;
    logic [25:0] data;

    // advance every stage when the output is free or being taken
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{force_mask: 1'b0, check_mask: 1'b0, textured: 1'b0,
                       raw_texture: 1'b0, dither_enable: 1'b0, blend_mode: BLEND_OPAQUE};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FORCE_MASK: r_cfg.force_mask <= i_cfg_data[0];
                CFG_CHECK_MASK: r_cfg.check_mask <= i_cfg_data[0];
                CFG_TEXTURED: r_cfg.textured <= i_cfg_data[0];
                CFG_RAW_TEXTURE: r_cfg.raw_texture <= i_cfg_data[0];
                CFG_DITHER: r_cfg.dither_enable <= i_cfg_data[0];
                CFG_BLEND_MODE: r_cfg.blend_mode <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign side_in = '{texel: s_axis_tdata[168:144], background: s_axis_tdata[193:169],
                       phase: s_axis_tdata[197:194]};

    gtbds_interp u_interp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_axis_tvalid),
        .i_weights(s_axis_tdata[71:0]), .i_colors(s_axis_tdata[143:72]),
        .i_side(side_in),
        .o_valid(iv), .o_acc(acc), .o_sum(sum), .o_side(side_i)
    );

    gtbds_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(iv), .i_acc(acc), .i_sum(sum), .i_side(side_i),
        .o_valid(dv), .o_col(col), .o_side(side_d)
    );

    gtbds_shade u_shade (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(dv), .i_col(col), .i_side(side_d), .i_cfg(r_cfg),
        .o_valid(m_axis_tvalid), .o_data(data)
    );

    assign m_axis_tdata = {6'd0, data};
endmodule
`default_nettype wire

// ----- hw/rtl/gtbds_checker.sv -----
`default_nettype none
module gtbds_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [31:0]  m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");
    a_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[25] |-> m_axis_tdata[24:0] == 25'd0)
        else $error("discarded pixel carries color or mask");
    a_reset: assert property (@(posedge i_clk) $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while pipe stalled");
endmodule

bind gouraud_texel_blend_dither_shader gtbds_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ----- tb/tb_gouraud_texel_blend_dither_shader_chk.sv -----
`default_nettype none
module tb_gouraud_texel_blend_dither_shader_chk (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic         i_in_ready,
    input  wire logic [199:0] i_in_data,
    input  wire logic         i_out_valid,
    input  wire logic         i_out_ready,
    input  wire logic [31:0]  i_out_data,
    input  wire logic         i_cfg_valid,
    input  wire logic         i_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [2:0]   i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_shaded
);
    import gtbds_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        we;
        logic        mask;
        logic [23:0] rgb;
    } t_pixel;

    t_cfg   regs;
    t_pixel pixel_q[$];

    function automatic int sat8(input int v);
        return (v < 0) ? 0 : (v > 255) ? 255 : v;
    endfunction

    function automatic int mix(input int b, input int f);
        case (regs.blend_mode)
            BLEND_AVG:     return sat8((b + f) / 2);
            BLEND_ADD:     return sat8(b + f);
            BLEND_SUB:     return sat8(b - f);
            BLEND_QUARTER: return sat8(b + f / 4);
            default:       return sat8(f);
        endcase
    endfunction

    function automatic t_pixel shade(input logic [199:0] d);
        logic [23:0] w[3];
        logic [23:0] vc[3];
        logic [24:0] tex, bg;
        logic [3:0]  ph;
        logic [63:0] sum, acc;
        int          col[3];
        int          ofs, t;
        logic        blend_on;
        t_pixel      p;
        for (int i = 0; i < 3; i++) begin
            w[i]  = d[24*i +: 24];
            vc[i] = d[72 + 24*i +: 24];
        end
        tex = d[144 +: 25];
        bg  = d[169 +: 25];
        ph  = d[194 +: 4];
        ofs = int'(dither_ofs(ph));
        p = '0;
        if (regs.check_mask && bg[24]) return p;
        sum = 64'(w[0]) + 64'(w[1]) + 64'(w[2]);
        if (sum == 0) sum = 1;
        for (int k = 0; k < 3; k++) begin
            acc = 64'(w[0]) * vc[0][8*k +: 8] + 64'(w[1]) * vc[1][8*k +: 8]
                + 64'(w[2]) * vc[2][8*k +: 8];
            col[k] = int'(acc / sum);
        end
        if (regs.textured) begin
            if (tex[23:0] == 0 && !tex[24]) return p;
            for (int k = 0; k < 3; k++) begin
                t = tex[8*k +: 8];
                if (!regs.raw_texture) begin
                    t = sat8((t * col[k]) / 128);
                    if (regs.dither_enable) t = sat8(t + ofs);
                end
                col[k] = t;
            end
            p.mask   = tex[24];
            blend_on = tex[24];
        end else begin
            if (regs.dither_enable)
                for (int k = 0; k < 3; k++) col[k] = sat8(col[k] + ofs);
            blend_on = 1'b1;
        end
        for (int k = 0; k < 3; k++)
            p.rgb[8*k +: 8] = 8'(blend_on ? mix(bg[8*k +: 8], col[k]) : sat8(col[k]));
        p.mask = p.mask | regs.force_mask;
        p.we   = 1'b1;
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_pixel got, want;
        int     nerr;
        nerr = 0;
        if (!i_rst_n) begin
            regs <= '{force_mask: 1'b0, check_mask: 1'b0, textured: 1'b0,
                      raw_texture: 1'b0, dither_enable: 1'b0, blend_mode: BLEND_OPAQUE};
            pixel_q.delete();
            o_errors  <= 0;
            o_shaded  <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) pixel_q.push_back(shade(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[25:0];
                o_shaded <= o_shaded + 1;
                if (pixel_q.size() == 0) begin
                    $error("unexpected pixel %h", i_out_data);
                    nerr++;
                end else begin
                    want = pixel_q.pop_front();
                    if (got.rgb !== want.rgb) begin
                        $error("out_color exp %h got %h", want.rgb, got.rgb);
                        nerr++;
                    end
                    if (got.mask !== want.mask) begin
                        $error("out_mask exp %b got %b", want.mask, got.mask);
                        nerr++;
                    end
                    if (got.we !== want.we) begin
                        $error("write_enable exp %b got %b", want.we, got.we);
                        nerr++;
                    end
                end
            end
            o_errors  <= o_errors + nerr;
            o_pending <= pixel_q.size();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FORCE_MASK:  regs.force_mask    <= i_cfg_data[0];
                    CFG_CHECK_MASK:  regs.check_mask    <= i_cfg_data[0];
                    CFG_TEXTURED:    regs.textured      <= i_cfg_data[0];
                    CFG_RAW_TEXTURE: regs.raw_texture   <= i_cfg_data[0];
                    CFG_DITHER:      regs.dither_enable <= i_cfg_data[0];
                    CFG_BLEND_MODE:  regs.blend_mode    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ----- tb/tb_gouraud_texel_blend_dither_shader.sv -----
`default_nettype none
module tb_gouraud_texel_blend_dither_shader;
    import gtbds_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous ceiling: ~860 items with long gaps on both sides stay far below it.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic         i_clk, i_rst_n;
    logic         s_axis_tvalid, s_axis_tready;
    logic [199:0] s_axis_tdata;
    logic         m_axis_tvalid, m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic         i_cfg_valid, o_cfg_ready;
    logic [2:0]   i_cfg_index, i_cfg_data;
    int           errors, pending, shaded, cycles, pixels_sent;
    bit           stall_ready;

    gouraud_texel_blend_dither_shader dut (.*);

    tb_gouraud_texel_blend_dither_shader_chk chk (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_shaded(shaded)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on total cycles.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly short gaps, occasionally a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random backpressure, with stall-free stretches.
    initial begin
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_ready) begin
                m_axis_tready <= 1'b1;
            end else begin
                n = gap_len();
                if (n == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (n - 1) @(posedge i_clk);
                end
            end
        end
    end

    // Hold valid through back-to-back writes; the caller drops it after the last.
    task automatic write_reg(input logic [2:0] idx, input logic [2:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Stop sending, wait until every expected pixel came back, then let the pipe settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic setup(input bit fm, cm, tx, raw, dit, input logic [2:0] mode);
        drain();
        write_reg(CFG_FORCE_MASK, {2'b0, fm});
        write_reg(CFG_CHECK_MASK, {2'b0, cm});
        write_reg(CFG_TEXTURED, {2'b0, tx});
        write_reg(CFG_RAW_TEXTURE, {2'b0, raw});
        write_reg(CFG_DITHER, {2'b0, dit});
        write_reg(CFG_BLEND_MODE, mode);
        i_cfg_valid <= 1'b0;
    endtask

    // Hand one pixel to the shader: hold valid until accepted, then maybe idle.
    task automatic send_pixel(input logic [23:0] wa, wb, wc, ca, cb, cc,
                              input logic [24:0] tex, bg, input logic [3:0] ph);
        int n;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b0, ph, bg, tex, cc, cb, ca, wc, wb, wa};
        do @(posedge i_clk); while (!s_axis_tready);
        pixels_sent++;
        n = gap_len();
        if (n != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [23:0] rand_weight();
        case ($urandom_range(0, 4))
            0:       return 24'($urandom_range(0, 3));
            1:       return 24'hFFFFFF - 24'($urandom_range(0, 3));
            2:       return 24'($urandom_range(0, 4095));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [24:0] rand_texel();
        case ($urandom_range(0, 5))
            0:       return {1'b0, 24'h0};          // transparent texel
            1:       return {1'b1, 24'h0};          // black but masked
            default: return 25'($urandom);
        endcase
    endfunction

    task automatic random_pixels(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_weight(), rand_weight(), rand_weight(),
                       24'($urandom), 24'($urandom), 24'($urandom),
                       rand_texel(), 25'($urandom), 4'($urandom));
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        cycles        = 0;
        pixels_sent   = 0;
        stall_ready   = 1'b0;
        i_rst_n       = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset config (opaque, untextured): extremes and zero weight sum.
        send_pixel(24'h0, 24'h0, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   25'h0, 25'h1FFFFFF, 4'd0);
        send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   24'hFFFFFF, 25'h1FFFFFF, 25'h0, 4'd15);
        send_pixel(24'hFFFFFF, 24'h0, 24'h0, 24'h123456, 24'h0, 24'h0,
                   25'h0, 25'h0, 4'd5);
        // Dither clamps at both ends, every blend mode including undefined ones.
        for (int m = 0; m < 8; m++) begin
            setup(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 3'(m));
            send_pixel(24'd1, 24'd0, 24'd0, 24'h000000, 24'd0, 24'd0,
                       25'h0, 25'h0FF80FF, 4'd0);
            send_pixel(24'd1, 24'd0, 24'd0, 24'hFFFFFF, 24'd0, 24'd0,
                       25'h0, 25'h1FF00FF, 4'd6);
        end
        // Textured: transparent texel, masked black, modulation saturation.
        setup(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, BLEND_ADD);
        send_pixel(24'd5, 24'd5, 24'd5, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   25'h0, 25'h0, 4'd3);
        send_pixel(24'd5, 24'd5, 24'd5, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   25'h1000000, 25'h0, 4'd3);
        send_pixel(24'd5, 24'd5, 24'd5, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   25'h0FFFFFF, 25'h1000000, 4'd3);  // protected by mask check
        send_pixel(24'd5, 24'd5, 24'd5, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   25'h1FFFFFF, 25'h0808080, 4'd12);
        setup(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, BLEND_SUB);
        send_pixel(24'd7, 24'd0, 24'd9, 24'h808080, 24'h0, 24'hFF00FF,
                   25'h1FF0001, 25'h0FFFFFF, 4'd10);
        send_pixel(24'd7, 24'd0, 24'd9, 24'h808080, 24'h0, 24'hFF00FF,
                   25'h0010203, 25'h0FFFFFF, 4'd10);

        // Random phases, each with a random setting; pause the sender sometimes
        // with the receiver unstalled so the pipe fully empties.
        for (int ph = 0; ph < 16; ph++) begin
            setup(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), 3'($urandom_range(0, 7)));
            random_pixels(52);
            if (ph % 5 == 2) begin
                stall_ready = 1'b1;
                drain();
                stall_ready = 1'b0;
            end
        end
        drain();

        $display("Shaded %0d of %0d pixels across all blend modes, texture and mask settings.",
                 shaded, pixels_sent);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
